>>> src/spe_pkg.sv
// ----------------------------------------------------------------------------
// spe_pkg
// Shared types and constants for the SPI EEPROM page sequencer.
// ----------------------------------------------------------------------------
package spe_pkg;

    // Geometry (PAGE_BYTES must be a power of two)
    localparam int PAGE_BYTES = 32;
    localparam int MEM_BYTES  = 8192;
    localparam int CNT_W      = 6;

    // Input opcodes
    localparam logic [2:0] OPC_READ  = 3'd0;
    localparam logic [2:0] OPC_WRITE = 3'd1;
    localparam logic [2:0] OPC_DATA  = 3'd2;
    localparam logic [2:0] OPC_ERASE = 3'd3;
    localparam logic [2:0] OPC_RX    = 3'd4;

    // Result kinds
    localparam logic [2:0] KIND_SEND   = 3'd0;
    localparam logic [2:0] KIND_RDATA  = 3'd1;
    localparam logic [2:0] KIND_DONE   = 3'd2;
    localparam logic [2:0] KIND_BUSY   = 3'd3;
    localparam logic [2:0] KIND_BADLEN = 3'd4;

    // EEPROM command bytes
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] FILL_BYTE = 8'hff;

    // Frame bodies the back end expands
    typedef enum logic [2:0] {
        BODY_NONE,
        BODY_STATUS,
        BODY_WHDR,
        BODY_RFRAME,
        BODY_ERASE
    } body_t;

    // One queued job: optional single result, frame body, optional done
    typedef struct packed {
        logic             pre_valid;
        logic [2:0]       pre_kind;
        logic [7:0]       pre_byte;
        logic             pre_fe;
        body_t            body;
        logic [15:0]      addr;
        logic [CNT_W-1:0] count;
        logic             done_after;
    } job_t;

endpackage

>>> src/spe_front.sv
// ----------------------------------------------------------------------------
// spe_front
// Request tracking: updates the sequencer state on each input transaction and
// emits the job that describes its results.
// ----------------------------------------------------------------------------
module spe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [2:0]          opcode,
    input  logic [15:0]         start_address,
    input  logic [15:0]         length,
    input  logic [7:0]          data_byte,
    output logic                job_wr,
    output spe_pkg::job_t       job
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_CHECK, PH_WDATA, PH_RDATA, PH_GAP, PH_POLL
    } phase_t;

    typedef enum logic [1:0] {OP_READ, OP_WRITE, OP_ERASE} oper_t;

    localparam logic [15:0] PAGE16     = 16'(spe_pkg::PAGE_BYTES);
    localparam logic [15:0] PAGE_MASK  = 16'(spe_pkg::PAGE_BYTES - 1);
    localparam logic [15:0] ERASE_REST = 16'(spe_pkg::MEM_BYTES - spe_pkg::PAGE_BYTES);
    localparam logic [16:0] MEM17      = 17'(spe_pkg::MEM_BYTES);
    localparam logic [spe_pkg::CNT_W-1:0] PAGE_CNT = spe_pkg::CNT_W'(spe_pkg::PAGE_BYTES);

    phase_t                    phase_reg, phase_next;
    oper_t                     oper_reg, oper_next;
    logic [15:0]               addr_reg, addr_next;
    logic [15:0]               rem_reg, rem_next;
    logic [spe_pkg::CNT_W-1:0] pbl_reg, pbl_next;
    logic [spe_pkg::CNT_W-1:0] fbc_reg, fbc_next;
    spe_pkg::job_t             job_c;

    logic [15:0]               room;
    logic [spe_pkg::CNT_W-1:0] chunk_page, chunk_room, fbc_inc, pbl_dec;
    logic [15:0]               addr_inc;

    // chunk sizes against a full page and the room left in this page
    assign room       = PAGE16 - (addr_reg & PAGE_MASK);
    assign chunk_page = (rem_reg < PAGE16) ? rem_reg[spe_pkg::CNT_W-1:0] : PAGE_CNT;
    assign chunk_room = (rem_reg < room) ? rem_reg[spe_pkg::CNT_W-1:0]
                                         : room[spe_pkg::CNT_W-1:0];
    assign fbc_inc    = fbc_reg + 1'b1;
    assign pbl_dec    = pbl_reg - 1'b1;
    assign addr_inc   = addr_reg + 16'd1;

    // next state and job
    always_comb
    begin
        phase_next = phase_reg;
        oper_next  = oper_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        pbl_next   = pbl_reg;
        fbc_next   = fbc_reg;
        job_c      = '0;
        job_c.body = spe_pkg::BODY_NONE;
        unique case (opcode) inside
            spe_pkg::OPC_READ, spe_pkg::OPC_WRITE, spe_pkg::OPC_ERASE:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    oper_next  = (opcode == spe_pkg::OPC_READ)  ? OP_READ :
                                 (opcode == spe_pkg::OPC_WRITE) ? OP_WRITE : OP_ERASE;
                    addr_next  = start_address;
                    rem_next   = length;
                    pbl_next   = '0;
                    fbc_next   = '0;
                    phase_next = PH_CHECK;
                    job_c.body = spe_pkg::BODY_STATUS;
                end
            end
            spe_pkg::OPC_DATA:
            begin
                if (phase_reg == PH_WDATA)
                begin
                    pbl_next        = pbl_dec;
                    addr_next       = addr_inc;
                    job_c.pre_valid = 1'b1;
                    job_c.pre_kind  = spe_pkg::KIND_SEND;
                    job_c.pre_byte  = data_byte;
                    job_c.pre_fe    = (pbl_dec == '0);
                    if (pbl_dec == '0)
                    begin
                        if (rem_reg == '0)
                        begin
                            phase_next       = PH_IDLE;
                            job_c.done_after = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_GAP;
                        end
                    end
                end
            end
            spe_pkg::OPC_RX:
            begin
                unique case (phase_reg)
                    PH_CHECK:
                    begin
                        if (data_byte[0])
                        begin
                            phase_next      = PH_IDLE;
                            job_c.pre_valid = 1'b1;
                            job_c.pre_kind  = spe_pkg::KIND_BUSY;
                        end
                        else if (oper_reg != OP_ERASE &&
                                 (rem_reg == '0 || {1'b0, rem_reg} > MEM17))
                        begin
                            phase_next      = PH_IDLE;
                            job_c.pre_valid = 1'b1;
                            job_c.pre_kind  = spe_pkg::KIND_BADLEN;
                        end
                        else if (oper_reg == OP_READ)
                        begin
                            rem_next    = rem_reg - 16'(chunk_page);
                            pbl_next    = chunk_page;
                            fbc_next    = '0;
                            phase_next  = PH_RDATA;
                            job_c.body  = spe_pkg::BODY_RFRAME;
                            job_c.addr  = addr_reg;
                            job_c.count = chunk_page;
                        end
                        else if (oper_reg == OP_WRITE)
                        begin
                            rem_next   = rem_reg - 16'(chunk_room);
                            pbl_next   = chunk_room;
                            phase_next = PH_WDATA;
                            job_c.body = spe_pkg::BODY_WHDR;
                            job_c.addr = addr_reg;
                        end
                        else
                        begin
                            // first erase page always full
                            addr_next   = PAGE16;
                            rem_next    = ERASE_REST;
                            pbl_next    = '0;
                            phase_next  = PH_GAP;
                            job_c.body  = spe_pkg::BODY_ERASE;
                            job_c.addr  = '0;
                            job_c.count = PAGE_CNT;
                        end
                    end
                    PH_GAP:
                    begin
                        phase_next = PH_POLL;
                        job_c.body = spe_pkg::BODY_STATUS;
                    end
                    PH_POLL:
                    begin
                        if (data_byte[0])
                        begin
                            job_c.body = spe_pkg::BODY_STATUS;
                        end
                        else if (oper_reg == OP_ERASE)
                        begin
                            job_c.body  = spe_pkg::BODY_ERASE;
                            job_c.addr  = addr_reg;
                            job_c.count = chunk_page;
                            addr_next   = addr_reg + 16'(chunk_page);
                            rem_next    = rem_reg - 16'(chunk_page);
                            pbl_next    = '0;
                            if (rem_reg == 16'(chunk_page))
                            begin
                                phase_next       = PH_IDLE;
                                job_c.done_after = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_GAP;
                            end
                        end
                        else
                        begin
                            rem_next   = rem_reg - 16'(chunk_page);
                            pbl_next   = chunk_page;
                            phase_next = PH_WDATA;
                            job_c.body = spe_pkg::BODY_WHDR;
                            job_c.addr = addr_reg;
                        end
                    end
                    PH_RDATA:
                    begin
                        fbc_next = fbc_inc;
                        if (fbc_inc > spe_pkg::CNT_W'(3))
                        begin
                            job_c.pre_valid = 1'b1;
                            job_c.pre_kind  = spe_pkg::KIND_RDATA;
                            job_c.pre_byte  = data_byte;
                            addr_next       = addr_inc;
                            pbl_next        = pbl_dec;
                            if (pbl_dec == '0)
                            begin
                                if (rem_reg == '0)
                                begin
                                    phase_next       = PH_IDLE;
                                    job_c.done_after = 1'b1;
                                end
                                else
                                begin
                                    // next read chunk from the advanced address
                                    rem_next    = rem_reg - 16'(chunk_page);
                                    pbl_next    = chunk_page;
                                    fbc_next    = '0;
                                    job_c.body  = spe_pkg::BODY_RFRAME;
                                    job_c.addr  = addr_inc;
                                    job_c.count = chunk_page;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign job    = job_c;
    assign job_wr = accept && (job_c.pre_valid || job_c.body != spe_pkg::BODY_NONE ||
                               job_c.done_after);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            oper_reg  <= OP_READ;
            addr_reg  <= '0;
            rem_reg   <= '0;
            pbl_reg   <= '0;
            fbc_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            oper_reg  <= oper_next;
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
            pbl_reg   <= pbl_next;
            fbc_reg   <= fbc_next;
        end
    end

endmodule

>>> src/spe_jobq.sv
// ----------------------------------------------------------------------------
// spe_jobq
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module spe_jobq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  spe_pkg::job_t wr_data,
    input  logic          rd,
    output spe_pkg::job_t rd_data,
    output logic          full,
    output logic          empty
);

    spe_pkg::job_t mem_reg [2];
    logic          wptr_reg, rptr_reg;
    logic [1:0]    cnt_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign rd_data = mem_reg[rptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr && !full)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (wr && !full)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd && !empty)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, (wr && !full)} - {1'b0, (rd && !empty)};
        end
    end

endmodule

>>> src/spe_back.sv
// ----------------------------------------------------------------------------
// spe_back
// Job expander: walks each job one result per cycle, when not stalled, into an output register.
// ----------------------------------------------------------------------------
module spe_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  spe_pkg::job_t q_head,
    output logic          q_rd,
    output logic          empty,
    input  logic          pop,
    output logic [2:0]    kind,
    output logic [7:0]    byte_value,
    output logic          frame_end,
    output logic          last
);

    typedef enum logic [1:0] {ST_IDLE, ST_PRE, ST_BODY, ST_DONE} stage_t;

    stage_t                    stage_reg, stage_next;
    spe_pkg::job_t             job_reg;
    logic [spe_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                      oval_reg;
    logic [2:0]                okind_reg;
    logic [7:0]                obyte_reg;
    logic                      ofe_reg, olast_reg;

    logic [6:0]                blen;
    logic                      body_last, step;
    logic [2:0]                r_kind;
    logic [7:0]                r_byte;
    logic                      r_fe, r_final;
    stage_t                    first_stage;

    assign step  = (stage_reg != ST_IDLE) && (!oval_reg || pop);
    assign q_rd  = (stage_reg == ST_IDLE) && !q_empty;

    // body length of the loaded job and first stage of the queue head job
    always_comb
    begin
        unique case (job_reg.body)
            spe_pkg::BODY_STATUS: blen = 7'd2;
            spe_pkg::BODY_WHDR:   blen = 7'd4;
            spe_pkg::BODY_RFRAME: blen = 7'd3 + {1'b0, job_reg.count};
            spe_pkg::BODY_ERASE:  blen = 7'd4 + {1'b0, job_reg.count};
            default:              blen = 7'd1;
        endcase
        body_last = ({1'b0, idx_reg} == blen - 7'd1);
        if (q_head.pre_valid)
            first_stage = ST_PRE;
        else if (q_head.body != spe_pkg::BODY_NONE)
            first_stage = ST_BODY;
        else
            first_stage = ST_DONE;
    end

    // current result and where to go next
    always_comb
    begin
        r_kind     = spe_pkg::KIND_SEND;
        r_byte     = 8'h00;
        r_fe       = 1'b0;
        r_final    = 1'b1;
        stage_next = ST_IDLE;
        idx_next   = '0;
        unique case (stage_reg)
            ST_PRE:
            begin
                r_kind = job_reg.pre_kind;
                r_byte = job_reg.pre_byte;
                r_fe   = job_reg.pre_fe;
                if (job_reg.body != spe_pkg::BODY_NONE)
                begin
                    r_final    = 1'b0;
                    stage_next = ST_BODY;
                end
                else if (job_reg.done_after)
                begin
                    r_final    = 1'b0;
                    stage_next = ST_DONE;
                end
            end
            ST_BODY:
            begin
                unique case (job_reg.body)
                    spe_pkg::BODY_STATUS:
                    begin
                        r_byte = (idx_reg == '0) ? spe_pkg::CMD_RDSR : 8'h00;
                        r_fe   = body_last;
                    end
                    spe_pkg::BODY_RFRAME:
                    begin
                        case (idx_reg)
                            spe_pkg::CNT_W'(0): r_byte = spe_pkg::CMD_READ;
                            spe_pkg::CNT_W'(1): r_byte = job_reg.addr[15:8];
                            spe_pkg::CNT_W'(2): r_byte = job_reg.addr[7:0];
                            default:            r_byte = 8'h00;
                        endcase
                        r_fe = body_last && (idx_reg >= spe_pkg::CNT_W'(3));
                    end
                    default:
                    begin
                        // write header, then fill bytes for erase
                        case (idx_reg)
                            spe_pkg::CNT_W'(0): r_byte = spe_pkg::CMD_WREN;
                            spe_pkg::CNT_W'(1): r_byte = spe_pkg::CMD_WRITE;
                            spe_pkg::CNT_W'(2): r_byte = job_reg.addr[15:8];
                            spe_pkg::CNT_W'(3): r_byte = job_reg.addr[7:0];
                            default:            r_byte = spe_pkg::FILL_BYTE;
                        endcase
                        r_fe = (idx_reg == '0) ||
                               (body_last && (idx_reg >= spe_pkg::CNT_W'(4)));
                    end
                endcase
                if (!body_last)
                begin
                    r_final    = 1'b0;
                    stage_next = ST_BODY;
                    idx_next   = idx_reg + 1'b1;
                end
                else if (job_reg.done_after)
                begin
                    r_final    = 1'b0;
                    stage_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                r_kind = spe_pkg::KIND_DONE;
            end
            default:
            begin
            end
        endcase
    end

    // job payload
    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            job_reg <= q_head;
        end
    end

    // sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= ST_IDLE;
            idx_reg   <= '0;
            oval_reg  <= 1'b0;
            okind_reg <= spe_pkg::KIND_SEND;
            obyte_reg <= 8'h00;
            ofe_reg   <= 1'b0;
            olast_reg <= 1'b0;
        end
        else
        begin
            if (q_rd)
            begin
                stage_reg <= first_stage;
                idx_reg   <= '0;
            end
            else if (step)
            begin
                stage_reg <= stage_next;
                idx_reg   <= idx_next;
            end
            if (step)
            begin
                oval_reg  <= 1'b1;
                okind_reg <= r_kind;
                obyte_reg <= r_byte;
                ofe_reg   <= r_fe;
                olast_reg <= r_final;
            end
            else if (pop)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    assign empty      = !oval_reg;
    assign kind       = okind_reg;
    assign byte_value = obyte_reg;
    assign frame_end  = ofe_reg;
    assign last       = olast_reg;

endmodule

>>> src/spi_eeprom_page_sequencer.sv
// ----------------------------------------------------------------------------
// spi_eeprom_page_sequencer
// Turns read, write and erase requests into serial EEPROM byte frames.
// ----------------------------------------------------------------------------
//  channel   handshake     payload
//  input     push / full   opcode, start_address, length, data_byte
//  result    empty / pop   kind, byte_value, frame_end, last
//
//  An input transaction is taken while the job queue has room.
//  Its results leave one per cycle from the expander while the output is not
//  stalled, after each job is first loaded from the queue.
//  Reset clears the request state, the queue and the output register.
//  A stalled result side fills the two-entry queue, then raises full.
// ----------------------------------------------------------------------------
module spi_eeprom_page_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  opcode,
    input  logic [15:0] start_address,
    input  logic [15:0] length,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [7:0]  byte_value,
    output logic        frame_end,
    output logic        last
);

    spe_pkg::job_t job_in, job_head;
    logic          job_wr, q_rd, q_empty, q_full;

    assign full = q_full;

    spe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (push && !q_full),
        .opcode        (opcode),
        .start_address (start_address),
        .length        (length),
        .data_byte     (data_byte),
        .job_wr        (job_wr),
        .job           (job_in)
    );

    spe_jobq u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (job_wr),
        .wr_data (job_in),
        .rd      (q_rd),
        .rd_data (job_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    spe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (job_head),
        .q_rd       (q_rd),
        .empty      (empty),
        .pop        (pop),
        .kind       (kind),
        .byte_value (byte_value),
        .frame_end  (frame_end),
        .last       (last)
    );

endmodule

>>> src/spe_checker.sv
// ----------------------------------------------------------------------------
// spe_checker
// Port-level checks on the result channel of the page sequencer.
// ----------------------------------------------------------------------------
module spe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [2:0] kind,
    input logic [7:0] byte_value,
    input logic       frame_end,
    input logic       last
);

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(byte_value)))
        else $error("result changed while stalled");

    // only sent bytes end a frame
    a_fe: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != spe_pkg::KIND_SEND) |-> !frame_end)
        else $error("frame_end on a non-send result");

    // status results close their transaction and carry no byte
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == spe_pkg::KIND_DONE || kind == spe_pkg::KIND_BUSY ||
                    kind == spe_pkg::KIND_BADLEN)) |-> (last && byte_value == 8'h00))
        else $error("status result malformed");

    // result kind is one of the defined codes
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (kind <= spe_pkg::KIND_BADLEN))
        else $error("undefined result kind");

endmodule

bind spi_eeprom_page_sequencer spe_checker u_spe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .byte_value (byte_value),
    .frame_end  (frame_end),
    .last       (last)
);

>>> tb/tb_spi_eeprom_page_sequencer.sv
// ----------------------------------------------------------------------------
// tb_spi_eeprom_page_sequencer
// Self-checking testbench. A transaction-level predictor tracks the request
// state and queues the expected frame bytes, read data and status results.
// Stimulus follows the predicted state to build well-formed request flows
// with random content, mixed with stray and out-of-range transactions.
// Both sides insert random gaps. The receiver also holds off once for a long
// stretch so that the input side fills and stalls.
// ----------------------------------------------------------------------------
module tb_spi_eeprom_page_sequencer;

    // Sequencer phases tracked by the predictor
    localparam int PH_IDLE  = 0;
    localparam int PH_CHECK = 1;
    localparam int PH_WDATA = 2;
    localparam int PH_RDATA = 3;
    localparam int PH_GAP   = 4;
    localparam int PH_POLL  = 5;

    // Operation held for the active request
    localparam int OPER_READ  = 0;
    localparam int OPER_WRITE = 1;
    localparam int OPER_ERASE = 2;

    localparam logic [7:0] STATUS_DUMMY = 8'h00;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] value;
        logic       fe;
        logic       lst;
    } eeprom_result_t;

    // ------------------------------------------------------------------------
    // Predictor and result checker
    // ------------------------------------------------------------------------
    class eeprom_scoreboard;
        int              phase;
        int              oper;
        logic [15:0]     cur_addr;
        logic [15:0]     rem_bytes;
        int              page_left;
        logic [5:0]      frame_cnt;
        eeprom_result_t  pending[$];
        eeprom_result_t  batch[$];
        int              errors;

        function new();
            phase = PH_IDLE;
            oper = OPER_READ;
            cur_addr = '0;
            rem_bytes = '0;
            page_left = 0;
            frame_cnt = '0;
            errors = 0;
        endfunction

        function void emit(logic [2:0] k, logic [7:0] v, logic fe);
            eeprom_result_t r;
            r.kind = k;
            r.value = v;
            r.fe = fe;
            r.lst = 1'b0;
            batch.push_back(r);
        endfunction

        function void status_frame();
            emit(spe_pkg::KIND_SEND, spe_pkg::CMD_RDSR, 1'b0);
            emit(spe_pkg::KIND_SEND, STATUS_DUMMY, 1'b1);
        endfunction

        function int take_chunk(int limit);
            int c;
            c = (rem_bytes < limit) ? int'(rem_bytes) : limit;
            rem_bytes = rem_bytes - 16'(c);
            page_left = c;
            return c;
        endfunction

        function void write_header();
            emit(spe_pkg::KIND_SEND, spe_pkg::CMD_WREN, 1'b1);
            emit(spe_pkg::KIND_SEND, spe_pkg::CMD_WRITE, 1'b0);
            emit(spe_pkg::KIND_SEND, cur_addr[15:8], 1'b0);
            emit(spe_pkg::KIND_SEND, cur_addr[7:0], 1'b0);
        endfunction

        function void read_frame();
            int c;
            c = take_chunk(spe_pkg::PAGE_BYTES);
            frame_cnt = '0;
            emit(spe_pkg::KIND_SEND, spe_pkg::CMD_READ, 1'b0);
            emit(spe_pkg::KIND_SEND, cur_addr[15:8], 1'b0);
            emit(spe_pkg::KIND_SEND, cur_addr[7:0], 1'b0);
            for (int i = 0; i < c; i++)
                emit(spe_pkg::KIND_SEND, 8'h00, i + 1 == c);
            phase = PH_RDATA;
        endfunction

        function void erase_page();
            int c;
            c = take_chunk(spe_pkg::PAGE_BYTES);
            write_header();
            for (int i = 0; i < c; i++)
                emit(spe_pkg::KIND_SEND, spe_pkg::FILL_BYTE, i + 1 == c);
            cur_addr = cur_addr + 16'(c);
            page_left = 0;
            if (rem_bytes == 0)
            begin
                phase = PH_IDLE;
                emit(spe_pkg::KIND_DONE, 8'h00, 1'b0);
            end
            else
                phase = PH_GAP;
        endfunction

        function void start_oper();
            if (oper == OPER_READ)
                read_frame();
            else if (oper == OPER_WRITE)
            begin
                void'(take_chunk(spe_pkg::PAGE_BYTES -
                                 (cur_addr % spe_pkg::PAGE_BYTES)));
                phase = PH_WDATA;
                write_header();
            end
            else
            begin
                // erase always starts at address zero, first page sent at once
                cur_addr = '0;
                rem_bytes = 16'(spe_pkg::MEM_BYTES - spe_pkg::PAGE_BYTES);
                phase = PH_GAP;
                write_header();
                for (int i = 0; i < spe_pkg::PAGE_BYTES; i++)
                    emit(spe_pkg::KIND_SEND, spe_pkg::FILL_BYTE,
                         i + 1 == spe_pkg::PAGE_BYTES);
                cur_addr = 16'(spe_pkg::PAGE_BYTES);
                page_left = 0;
            end
        endfunction

        // Accepted input transaction: compute and queue its results
        function void note_input(logic [2:0] op, logic [15:0] addr,
                                 logic [15:0] len, logic [7:0] d);
            eeprom_result_t r;
            batch.delete();
            if (op == spe_pkg::OPC_READ || op == spe_pkg::OPC_WRITE ||
                op == spe_pkg::OPC_ERASE)
            begin
                if (phase == PH_IDLE)
                begin
                    oper = (op == spe_pkg::OPC_READ)  ? OPER_READ :
                           (op == spe_pkg::OPC_WRITE) ? OPER_WRITE : OPER_ERASE;
                    cur_addr = addr;
                    rem_bytes = len;
                    page_left = 0;
                    frame_cnt = '0;
                    phase = PH_CHECK;
                    status_frame();
                end
            end
            else if (op == spe_pkg::OPC_DATA)
            begin
                if (phase == PH_WDATA)
                begin
                    page_left = page_left - 1;
                    cur_addr = cur_addr + 16'd1;
                    emit(spe_pkg::KIND_SEND, d, page_left == 0);
                    if (page_left == 0)
                    begin
                        if (rem_bytes == 0)
                        begin
                            phase = PH_IDLE;
                            emit(spe_pkg::KIND_DONE, 8'h00, 1'b0);
                        end
                        else
                            phase = PH_GAP;
                    end
                end
            end
            else if (op == spe_pkg::OPC_RX)
            begin
                case (phase)
                    PH_CHECK:
                    begin
                        if (d[0])
                        begin
                            phase = PH_IDLE;
                            emit(spe_pkg::KIND_BUSY, 8'h00, 1'b0);
                        end
                        else if (oper != OPER_ERASE &&
                                 (rem_bytes == 0 ||
                                  int'(rem_bytes) > spe_pkg::MEM_BYTES))
                        begin
                            phase = PH_IDLE;
                            emit(spe_pkg::KIND_BADLEN, 8'h00, 1'b0);
                        end
                        else
                            start_oper();
                    end
                    PH_GAP:
                    begin
                        phase = PH_POLL;
                        status_frame();
                    end
                    PH_POLL:
                    begin
                        if (d[0])
                            status_frame();
                        else if (oper == OPER_ERASE)
                            erase_page();
                        else
                        begin
                            void'(take_chunk(spe_pkg::PAGE_BYTES));
                            phase = PH_WDATA;
                            write_header();
                        end
                    end
                    PH_RDATA:
                    begin
                        // first three received bytes belong to the header
                        frame_cnt = frame_cnt + 6'd1;
                        if (frame_cnt > 3)
                        begin
                            emit(spe_pkg::KIND_RDATA, d, 1'b0);
                            cur_addr = cur_addr + 16'd1;
                            page_left = page_left - 1;
                            if (page_left == 0)
                            begin
                                if (rem_bytes == 0)
                                begin
                                    phase = PH_IDLE;
                                    emit(spe_pkg::KIND_DONE, 8'h00, 1'b0);
                                end
                                else
                                    read_frame();
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].lst = 1'b1;
            while (batch.size() > 0)
            begin
                r = batch.pop_front();
                pending.push_back(r);
            end
        endfunction

        // Accepted result transaction: compare with the oldest expectation
        function void check_result(logic [2:0] k, logic [7:0] v, logic fe, logic lst);
            eeprom_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: kind %0d byte_value %0h", k, v);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind)
            begin
                $error("kind mismatch: expected %0d, actual %0d", e.kind, k);
                errors++;
            end
            if (v !== e.value)
            begin
                $error("byte_value mismatch: expected %0h, actual %0h", e.value, v);
                errors++;
            end
            if (fe !== e.fe)
            begin
                $error("frame_end mismatch: expected %0b, actual %0b", e.fe, fe);
                errors++;
            end
            if (lst !== e.lst)
            begin
                $error("last mismatch: expected %0b, actual %0b", e.lst, lst);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [2:0]  opcode;
    logic [15:0] start_address;
    logic [15:0] length;
    logic [7:0]  data_byte;
    logic        empty;
    logic        pop;
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic        frame_end;
    logic        last;

    eeprom_scoreboard sb;
    int               sent_cnt;
    int               recv_cnt;
    bit               long_hold_done;

    spi_eeprom_page_sequencer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .start_address (start_address),
        .length        (length),
        .data_byte     (data_byte),
        .empty         (empty),
        .pop           (pop),
        .kind          (kind),
        .byte_value    (byte_value),
        .frame_end     (frame_end),
        .last          (last)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Mostly short gaps, a few long ones, and stretches with none
    function automatic int pick_gap(int idx);
        int r;
        if ((idx / 40) % 3 == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one input transaction and wait until it is taken
    task automatic send_item(logic [2:0] op, logic [15:0] addr, logic [15:0] len,
                             logic [7:0] d);
        int gap;
        gap = pick_gap(sent_cnt);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push          <= 1'b1;
        opcode        <= op;
        start_address <= addr;
        length        <= len;
        data_byte     <= d;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_input(op, addr, len, d);
        sent_cnt++;
    endtask

    // Next well-formed transaction for the predicted phase
    task automatic step_flow(int busy_pct);
        logic [7:0]  d;
        logic [15:0] len;
        int          r;
        d = 8'($urandom);
        case (sb.phase) inside
            PH_IDLE:
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    len = 16'($urandom_range(1, 70));
                else if (r < 88)
                    len = 16'($urandom_range(71, 100));
                else if (r < 93)
                    len = 16'd0;
                else
                    len = 16'($urandom_range(spe_pkg::MEM_BYTES + 1, 65535));
                send_item(($urandom_range(0, 1) == 0) ? spe_pkg::OPC_READ
                                                      : spe_pkg::OPC_WRITE,
                          16'($urandom), len, d);
            end
            PH_CHECK, PH_POLL:
            begin
                d[0] = ($urandom_range(0, 99) < busy_pct);
                send_item(spe_pkg::OPC_RX, 16'($urandom), 16'($urandom), d);
            end
            PH_WDATA:
                send_item(spe_pkg::OPC_DATA, 16'($urandom), 16'($urandom), d);
            default:
                send_item(spe_pkg::OPC_RX, 16'($urandom), 16'($urandom), d);
        endcase
    endtask

    // Request followed by a given status reply, then run to completion
    task automatic run_request(logic [2:0] op, logic [15:0] addr, logic [15:0] len,
                               logic busy);
        send_item(op, addr, len, 8'($urandom));
        send_item(spe_pkg::OPC_RX, 16'($urandom), 16'($urandom), {7'($urandom), busy});
        while (sb.phase != PH_IDLE)
            step_flow(10);
    endtask

    // Stray transaction that keeps clear of starting a request in idle
    task automatic send_stray();
        logic [2:0] op;
        op = 3'($urandom_range(0, 7));
        if (sb.phase == PH_IDLE && (op == spe_pkg::OPC_READ || op == spe_pkg::OPC_WRITE ||
                                    op == spe_pkg::OPC_ERASE))
            op = 3'($urandom_range(5, 7));
        send_item(op, 16'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // Stimulus
    initial
    begin
        sb = new();
        sent_cnt = 0;
        rst_n = 1'b0;
        push = 1'b0;
        opcode = spe_pkg::OPC_READ;
        start_address = '0;
        length = '0;
        data_byte = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray inputs in idle: data byte, received byte, unused opcodes
        send_item(spe_pkg::OPC_DATA, 16'hffff, 16'hffff, 8'hff);
        send_item(spe_pkg::OPC_RX, 16'h0000, 16'h0000, 8'h00);
        send_item(3'd5, 16'h1234, 16'h0001, 8'h5a);
        send_item(3'd7, 16'hffff, 16'hffff, 8'hff);
        // busy status rejects read, write and erase
        run_request(spe_pkg::OPC_READ, 16'h0000, 16'd4, 1'b1);
        run_request(spe_pkg::OPC_WRITE, 16'h0010, 16'd4, 1'b1);
        run_request(spe_pkg::OPC_ERASE, 16'h0000, 16'd0, 1'b1);
        // length rejects: zero, one above memory, all ones
        run_request(spe_pkg::OPC_READ, 16'h0000, 16'd0, 1'b0);
        run_request(spe_pkg::OPC_WRITE, 16'h0000, 16'(spe_pkg::MEM_BYTES + 1), 1'b0);
        run_request(spe_pkg::OPC_READ, 16'hffff, 16'hffff, 1'b0);
        // write crossing a page and wrapping the address space
        run_request(spe_pkg::OPC_WRITE, 16'hfffe, 16'd3, 1'b0);
        // read spanning two chunks, with a second request sent while it is in progress
        send_item(spe_pkg::OPC_READ, 16'h1ff0, 16'd33, 8'h00);
        send_item(spe_pkg::OPC_RX, 16'h0000, 16'h0000, 8'hfe);
        send_item(spe_pkg::OPC_WRITE, 16'h0000, 16'd1, 8'h00);
        while (sb.phase != PH_IDLE)
            step_flow(0);
        // full chip erase with busy polls in between pages
        run_request(spe_pkg::OPC_ERASE, 16'hffff, 16'hffff, 1'b0);

        // random part: mostly well-formed flows, some stray transactions
        while (sent_cnt < 450)
        begin
            if ($urandom_range(0, 99) < 8)
                send_stray();
            else
                step_flow(15);
        end
        // finish any open request
        while (sb.phase != PH_IDLE)
            step_flow(0);
        push <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result side: random pops, one long hold-off counted in cycles
    initial
    begin
        int hold;
        int cyc;
        int r;
        recv_cnt = 0;
        long_hold_done = 1'b0;
        hold = 0;
        cyc = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (pop && !empty)
            begin
                sb.check_result(kind, byte_value, frame_end, last);
                recv_cnt++;
            end
            if (!long_hold_done && recv_cnt >= 150)
            begin
                long_hold_done = 1'b1;
                hold = 400;
            end
            if (hold > 0)
            begin
                hold--;
                pop <= 1'b0;
            end
            else if ((cyc / 300) % 4 == 0)
                pop <= 1'b1;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    pop <= 1'b1;
                else
                begin
                    pop <= 1'b0;
                    hold = (r < 92) ? $urandom_range(0, 2) : $urandom_range(6, 25);
                end
            end
        end
    end

    // Timeout
    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
